@@ design/xorshift64star_rng_core_defines.svh @@
// ----------------------------------------------------------------------------
// xorshift64star_rng_core_defines
// Assertion macros for the checker file of the generator block.
// ----------------------------------------------------------------------------
`ifndef XORSHIFT64STAR_RNG_CORE_DEFINES_SVH
`define XORSHIFT64STAR_RNG_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and masked while rst_n is low.
`define XSRNG_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xsrng same-cycle check failed");

// Next-cycle implication, sampled on clk and masked while rst_n is low.
`define XSRNG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("xsrng next-cycle check failed");

`endif

@@ design/xsrng_pkg.sv @@
// ----------------------------------------------------------------------------
// xsrng_pkg
// Constants, codes and controller/datapath interface types of the generator.
// ----------------------------------------------------------------------------
package xsrng_pkg;

    localparam logic [63:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B    = 64'h94d049bb133111eb;
    localparam logic [63:0] ZERO_SUBST   = 64'h1234567890abcdef;
    localparam logic [63:0] STAR_MUL     = 64'h2545f4914f6cdd1d;

    // A 64x64 low product is built from three 32x32 partial products.
    localparam int MUL_STEPS = 3;
    // Restoring remainder, one dividend bit per step.
    localparam int DIV_STEPS = 32;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        FUNC_RAW    = 2'd0,
        FUNC_RANGE  = 2'd1,
        FUNC_CHANCE = 2'd2
    } func_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD_SEED,
        DP_MUL,
        DP_MIX_G,
        DP_MIX_A,
        DP_MIX_B,
        DP_LATCH,
        DP_ADVANCE,
        DP_DIV_INIT,
        DP_DIV_STEP,
        DP_LOAD_OUT
    } dp_op_t;

    typedef enum logic [1:0] {
        KC_GAMMA,
        KC_MIX_A,
        KC_MIX_B,
        KC_STAR
    } kc_t;

    typedef struct packed {
        dp_op_t      op;
        kc_t         kc;
        logic [1:0]  mstep;
        logic        seed_wr;
    } xsrng_cmd_t;

    typedef struct packed {
        func_t       func;
        logic        empty;
        logic        span_zero;
    } xsrng_sts_t;

endpackage

@@ design/xsrng_ctrl.sv @@
// ----------------------------------------------------------------------------
// xsrng_ctrl
// Sequencer for seed expansion, state advance, remainder and result hand-off.
// ----------------------------------------------------------------------------
module xsrng_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  xsrng_pkg::xsrng_sts_t sts,
    output xsrng_pkg::xsrng_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_LOAD,
        S_MULG,
        S_MIXG,
        S_MULA,
        S_MIXA,
        S_MULB,
        S_MIXB,
        S_IDLE,
        S_ADV,
        S_MULS,
        S_POST,
        S_DIV,
        S_DONE
    } state_t;

    localparam logic [xsrng_pkg::CNT_W-1:0] MUL_LAST =
        xsrng_pkg::CNT_W'(xsrng_pkg::MUL_STEPS - 1);
    localparam logic [xsrng_pkg::CNT_W-1:0] DIV_LAST =
        xsrng_pkg::CNT_W'(xsrng_pkg::DIV_STEPS - 1);

    state_t                      state_reg, state_next;
    logic [xsrng_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        advances;
    logic                        mul_last;

    assign in_stall  = (state_reg != S_IDLE) || cfg_we;
    assign out_valid = out_valid_reg;
    assign mul_last  = (cnt_reg == MUL_LAST);

    assign advances = (sts.func == xsrng_pkg::FUNC_RAW)
                   || (sts.func == xsrng_pkg::FUNC_CHANCE)
                   || ((sts.func == xsrng_pkg::FUNC_RANGE) && !sts.empty);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.op         = xsrng_pkg::DP_NOP;
        cmd.kc         = xsrng_pkg::KC_STAR;
        cmd.mstep      = cnt_reg[1:0];
        cmd.seed_wr    = cfg_we;

        case (state_reg)
            S_LOAD:
            begin
                cmd.op     = xsrng_pkg::DP_LOAD_SEED;
                cnt_next   = '0;
                state_next = S_MULG;
            end
            S_MULG, S_MULA, S_MULB, S_MULS:
            begin
                cmd.op = xsrng_pkg::DP_MUL;
                case (state_reg)
                    S_MULG:  cmd.kc = xsrng_pkg::KC_GAMMA;
                    S_MULA:  cmd.kc = xsrng_pkg::KC_MIX_A;
                    S_MULB:  cmd.kc = xsrng_pkg::KC_MIX_B;
                    default: cmd.kc = xsrng_pkg::KC_STAR;
                endcase
                if (mul_last)
                begin
                    cnt_next = '0;
                    case (state_reg)
                        S_MULG:  state_next = S_MIXG;
                        S_MULA:  state_next = S_MIXA;
                        S_MULB:  state_next = S_MIXB;
                        default: state_next = S_POST;
                    endcase
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_MIXG:
            begin
                cmd.op     = xsrng_pkg::DP_MIX_G;
                state_next = S_MULA;
            end
            S_MIXA:
            begin
                cmd.op     = xsrng_pkg::DP_MIX_A;
                state_next = S_MULB;
            end
            S_MIXB:
            begin
                cmd.op     = xsrng_pkg::DP_MIX_B;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = xsrng_pkg::DP_LATCH;
                    state_next = S_ADV;
                end
            end
            S_ADV:
            begin
                cnt_next = '0;
                if (advances)
                begin
                    cmd.op     = xsrng_pkg::DP_ADVANCE;
                    state_next = S_MULS;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_POST:
            begin
                cnt_next = '0;
                if ((sts.func == xsrng_pkg::FUNC_RANGE) && !sts.span_zero)
                begin
                    cmd.op     = xsrng_pkg::DP_DIV_INIT;
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DIV:
            begin
                cmd.op = xsrng_pkg::DP_DIV_STEP;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                // Hand the result over as soon as the output slot frees up.
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.op         = xsrng_pkg::DP_LOAD_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase

        // A seed write restarts the expansion from wherever we are.
        if (cfg_we)
        begin
            state_next = S_LOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ design/xsrng_dp.sv @@
// ----------------------------------------------------------------------------
// xsrng_dp
// Generator state, shared 32x32 multiplier, remainder unit and result registers.
// ----------------------------------------------------------------------------
module xsrng_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  xsrng_pkg::xsrng_cmd_t cmd,
    output xsrng_pkg::xsrng_sts_t sts,
    input  logic [31:0]           cfg_wdata,
    input  logic [1:0]            func,
    input  logic signed [31:0]    lo,
    input  logic signed [31:0]    hi,
    input  logic [24:0]           prob,
    output logic [31:0]           draw,
    output logic signed [31:0]    number,
    output logic                  hit
);

    logic [31:0]        seed_reg;
    logic [63:0]        gen_reg;
    logic [63:0]        z_reg;
    logic [63:0]        acc_reg;
    logic [31:0]        rem_reg;
    logic [31:0]        dvd_reg;
    logic [1:0]         func_reg;
    logic signed [31:0] lo_reg;
    logic signed [31:0] hi_reg;
    logic [24:0]        prob_reg;
    logic [31:0]        draw_reg;
    logic [31:0]        number_reg;
    logic               hit_reg;

    logic [63:0] kconst;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;
    logic [63:0] adv_x1, adv_x2, adv_x3;
    logic [63:0] mixg_sum;
    logic [63:0] mixb_val;
    logic [31:0] span;
    logic [32:0] rem_sh;
    logic        rem_ge;
    logic [32:0] rem_sub;
    logic [31:0] cur_draw;
    logic        empty;
    logic [31:0] res_draw;
    logic [31:0] res_number;
    logic        res_hit;

    always_comb
    begin
        case (cmd.kc)
            xsrng_pkg::KC_GAMMA: kconst = xsrng_pkg::GOLDEN_GAMMA;
            xsrng_pkg::KC_MIX_A: kconst = xsrng_pkg::MIX_MUL_A;
            xsrng_pkg::KC_MIX_B: kconst = xsrng_pkg::MIX_MUL_B;
            default:             kconst = xsrng_pkg::STAR_MUL;
        endcase
    end

    // Partial products of the low 64 bits: lo*lo, then hi*lo and lo*hi
    // folded into the upper word.
    always_comb
    begin
        case (cmd.mstep)
            2'd1:
            begin
                mul_a = z_reg[63:32];
                mul_b = kconst[31:0];
            end
            2'd2:
            begin
                mul_a = z_reg[31:0];
                mul_b = kconst[63:32];
            end
            default:
            begin
                mul_a = z_reg[31:0];
                mul_b = kconst[31:0];
            end
        endcase
    end

    assign prod = 64'(mul_a) * 64'(mul_b);

    assign adv_x1 = gen_reg ^ (gen_reg >> 12);
    assign adv_x2 = adv_x1 ^ (adv_x1 << 25);
    assign adv_x3 = adv_x2 ^ (adv_x2 >> 27);

    assign mixg_sum = acc_reg + xsrng_pkg::GOLDEN_GAMMA;
    assign mixb_val = acc_reg ^ (acc_reg >> 31);

    assign span    = $unsigned(hi_reg) - $unsigned(lo_reg) + 32'd1;
    assign empty   = (hi_reg <= lo_reg);
    assign rem_sh  = {rem_reg, dvd_reg[31]};
    assign rem_ge  = (rem_sh >= {1'b0, span});
    assign rem_sub = rem_sh - {1'b0, span};

    assign cur_draw = acc_reg[63:32];

    assign sts.func      = xsrng_pkg::func_t'(func_reg);
    assign sts.empty     = empty;
    assign sts.span_zero = (span == 32'd0);

    always_comb
    begin
        res_draw   = 32'd0;
        res_number = 32'd0;
        res_hit    = 1'b0;
        case (func_reg)
            xsrng_pkg::FUNC_RAW:
            begin
                res_draw = cur_draw;
            end
            xsrng_pkg::FUNC_RANGE:
            begin
                if (empty)
                begin
                    res_number = $unsigned(lo_reg);
                end
                else
                begin
                    res_draw = cur_draw;
                    if (span == 32'd0)
                    begin
                        res_number = $unsigned(lo_reg) + cur_draw;
                    end
                    else
                    begin
                        res_number = $unsigned(lo_reg) + rem_reg;
                    end
                end
            end
            xsrng_pkg::FUNC_CHANCE:
            begin
                res_draw = cur_draw;
                res_hit  = ({1'b0, cur_draw[31:8]} < prob_reg);
            end
            default:
            begin
                res_draw = 32'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= 32'd0;
        end
        else if (cmd.seed_wr)
        begin
            seed_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            xsrng_pkg::DP_LOAD_SEED:
            begin
                z_reg <= {32'd0, seed_reg};
            end
            xsrng_pkg::DP_MUL:
            begin
                if (cmd.mstep == 2'd0)
                begin
                    acc_reg <= prod;
                end
                else
                begin
                    acc_reg <= {acc_reg[63:32] + prod[31:0], acc_reg[31:0]};
                end
            end
            xsrng_pkg::DP_MIX_G:
            begin
                z_reg <= mixg_sum ^ (mixg_sum >> 30);
            end
            xsrng_pkg::DP_MIX_A:
            begin
                z_reg <= acc_reg ^ (acc_reg >> 27);
            end
            xsrng_pkg::DP_MIX_B:
            begin
                // A zero state would lock the generator; swap in a constant.
                gen_reg <= (mixb_val != 64'd0) ? mixb_val : xsrng_pkg::ZERO_SUBST;
            end
            xsrng_pkg::DP_LATCH:
            begin
                func_reg <= func;
                lo_reg   <= lo;
                hi_reg   <= hi;
                prob_reg <= prob;
            end
            xsrng_pkg::DP_ADVANCE:
            begin
                gen_reg <= adv_x3;
                z_reg   <= adv_x3;
            end
            xsrng_pkg::DP_DIV_INIT:
            begin
                rem_reg <= 32'd0;
                dvd_reg <= cur_draw;
            end
            xsrng_pkg::DP_DIV_STEP:
            begin
                rem_reg <= rem_ge ? rem_sub[31:0] : rem_sh[31:0];
                dvd_reg <= {dvd_reg[30:0], 1'b0};
            end
            xsrng_pkg::DP_LOAD_OUT:
            begin
                draw_reg   <= res_draw;
                number_reg <= res_number;
                hit_reg    <= res_hit;
            end
            default:
            begin
                z_reg <= z_reg;
            end
        endcase
    end

    assign draw   = draw_reg;
    assign number = $signed(number_reg);
    assign hit    = hit_reg;

endmodule

@@ design/xorshift64star_rng_core.sv @@
// ----------------------------------------------------------------------------
// xorshift64star_rng_core
// xorshift64* generator with splitmix64 seeding, range and chance requests.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request item: func, lo,
//   hi, prob. Output channel (out_valid / out_stall) returns one result item
//   per request: draw, number, hit. An item moves when valid is high and
//   stall is low. cfg_we/cfg_wdata write the seed; the state is re-expanded.
// The sequencer and the shared 32x32 multiplier (three passes per 64-bit
// product) set the path from accept to out_valid:
//   raw draw and chance test       state advance and star product
//   range request                  as above, then a 32-step restoring remainder
//   range with full 2^32 span      state advance and product, no remainder
//   empty range, unused func code  no advance, result only
//   The next item can be taken in the cycle after the result is registered.
// Reset and seed writes run a splitmix64 expansion (three 64-bit
// products) during which in_stall stays high.
// A stalled result holds in the output register while the next item is
// accepted and worked; that item then waits until the slot empties.
// ----------------------------------------------------------------------------
module xorshift64star_rng_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         func,
    input  logic signed [31:0] lo,
    input  logic signed [31:0] hi,
    input  logic [24:0]        prob,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [31:0]        draw,
    output logic signed [31:0] number,
    output logic               hit
);

    // Commands from the sequencer, request status back from the datapath.
    xsrng_pkg::xsrng_cmd_t cmd;
    xsrng_pkg::xsrng_sts_t sts;

    // Sequencer: seed expansion, advance, remainder loop, result hand-off.
    xsrng_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath: generator state, multiplier, remainder and output registers.
    xsrng_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_wdata (cfg_wdata),
        .func      (func),
        .lo        (lo),
        .hi        (hi),
        .prob      (prob),
        .draw      (draw),
        .number    (number),
        .hit       (hit)
    );

endmodule

@@ design/xsrng_chk.sv @@
// ----------------------------------------------------------------------------
// xsrng_chk
// Port-level checks of the generator block, bound to the top level.
// ----------------------------------------------------------------------------
`include "xorshift64star_rng_core_defines.svh"

module xsrng_chk (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] draw,
    input  logic [31:0] number,
    input  logic        hit
);

    // Hold a stalled result.
    `XSRNG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(draw) && $stable(number) && $stable(hit))

    // Chance hits come only from chance requests, which carry no range number.
    `XSRNG_ASSERT_SAME(a_hit_no_number, out_valid && hit, number == 32'd0)

    // Busy right after taking an item.
    `XSRNG_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

    // Seed expansion blocks requests.
    `XSRNG_ASSERT_NEXT(a_busy_after_seed, cfg_we, in_stall)

endmodule

bind xorshift64star_rng_core xsrng_chk u_xsrng_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .draw      (draw),
    .number    (number),
    .hit       (hit)
);
